// ----- src/shs_pkg.sv -----
// ---------------------------------------------------------------------------
// shs_pkg - shared types and constants
// Data width, queue depth and the queue entry type used between the front
// and the back of the shell sort block.
// ---------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 4;

    // One loaded element plus its end-of-set mark
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     done;
    } qitem_t;

endpackage : shs_pkg

`default_nettype wire

// ----- src/shs_if.sv -----
// ---------------------------------------------------------------------------
// shs_in_if / shs_out_if - valid/ready channels
// Input channel carries one element, output channel one sorted element.
// ---------------------------------------------------------------------------
`default_nettype none

interface shs_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [shs_pkg::DATA_W-1:0]   in_value;
    logic                                in_last;

    modport source (output valid, output in_value, output in_last, input ready);
    modport sink   (input valid, input in_value, input in_last, output ready);
endinterface : shs_in_if

interface shs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [shs_pkg::DATA_W-1:0]   out_value;
    logic                                out_last;

    modport source (output valid, output out_value, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_last, output ready);
endinterface : shs_out_if

`default_nettype wire

// ----- src/shs_front.sv -----
// ---------------------------------------------------------------------------
// shs_front - input acceptance and set classification
// Counts the elements of the current set and marks the element that ends it:
// the one flagged last, or the one that fills the store.
// ---------------------------------------------------------------------------
`default_nettype none

module shs_front #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    shs_in_if.sink           item,
    output logic             push_valid,
    input  logic             push_ready,
    output shs_pkg::qitem_t  push_data
);

    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic [IW-1:0] cnt_reg;
    logic [IW-1:0] cnt_next;
    logic          done;
    logic          take;

    assign done = item.in_last || (cnt_reg == IW'(MAX_ELEMENTS - 1));
    assign take = item.valid && push_ready;

    assign item.ready       = push_ready;
    assign push_valid       = item.valid;
    assign push_data.value  = item.in_value;
    assign push_data.done   = done;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (take)
        begin
            cnt_next = done ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule : shs_front

`default_nettype wire

// ----- src/shs_queue.sv -----
// ---------------------------------------------------------------------------
// shs_queue - short FIFO between front and back
// Lets the front keep taking elements while the back sorts or emits.
// ---------------------------------------------------------------------------
`default_nettype none

module shs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  shs_pkg::qitem_t  push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output shs_pkg::qitem_t  pop_data
);

    localparam int DEPTH = shs_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    shs_pkg::qitem_t slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : shs_queue

`default_nettype wire

// ----- src/shs_back.sv -----
// ---------------------------------------------------------------------------
// shs_back - element store, shell sort sequencer and result stage
// Loads a set from the queue into a store with one read and one write port,
// sorts it in place with halving gaps and gapped insertion, then reads it
// out in order.
// ---------------------------------------------------------------------------
`default_nettype none

module shs_back #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  shs_pkg::qitem_t  pop_data,
    shs_out_if.source        result
);

    localparam int DW = shs_pkg::DATA_W;
    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [7:0] {
        ST_LOAD    = 8'b0000_0001,
        ST_GAP     = 8'b0000_0010,
        ST_KEY_RD  = 8'b0000_0100,
        ST_KEY_CAP = 8'b0000_1000,
        ST_CMP     = 8'b0001_0000,
        ST_PUT     = 8'b0010_0000,
        ST_OUT_RD  = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CW-1:0]        n_reg;
    logic [CW-1:0]        n_next;
    logic [IW-1:0]        gap_reg;
    logic [IW-1:0]        gap_next;
    logic [IW-1:0]        pos_reg;
    logic [IW-1:0]        pos_next;
    logic [IW-1:0]        p_reg;
    logic [IW-1:0]        p_next;
    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        idx_next;
    logic signed [DW-1:0] key_reg;
    logic signed [DW-1:0] key_next;

    logic [DW-1:0]        store_reg [MAX_ELEMENTS];
    logic signed [DW-1:0] rd_data_reg;
    logic [IW-1:0]        rd_addr;
    logic                 we;
    logic [IW-1:0]        wa;
    logic [DW-1:0]        wd;

    logic [CW-1:0]        pos_inc;
    logic [IW-1:0]        gap_half;
    logic [IW-1:0]        p_dn;
    logic                 less;
    logic                 is_last;
    logic                 out_take;

    assign pos_inc  = CW'(pos_reg) + 1'b1;
    assign gap_half = gap_reg >> 1;
    assign p_dn     = p_reg - gap_reg;
    assign less     = key_reg < rd_data_reg;
    assign is_last  = (CW'(idx_reg) + 1'b1) == n_reg;
    assign out_take = (state_reg == ST_OUT) && result.ready;

    assign pop_ready        = (state_reg == ST_LOAD);
    assign result.valid     = (state_reg == ST_OUT);
    assign result.out_value = rd_data_reg;
    assign result.out_last  = is_last;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        gap_next   = gap_reg;
        pos_next   = pos_reg;
        p_next     = p_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        rd_addr    = pos_reg;
        we         = 1'b0;
        wa         = p_reg;
        wd         = key_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (pop_valid)
                begin
                    we     = 1'b1;
                    wa     = n_reg[IW-1:0];
                    wd     = pop_data.value;
                    n_next = n_reg + 1'b1;
                    if (pop_data.done)
                    begin
                        state_next = ST_GAP;
                    end
                end
            end

            ST_GAP:
            begin
                gap_next = IW'(n_reg >> 1);
                pos_next = IW'(n_reg >> 1);
                idx_next = '0;
                state_next = ((n_reg >> 1) == '0) ? ST_OUT_RD : ST_KEY_RD;
            end

            ST_KEY_RD:
            begin
                rd_addr    = pos_reg;
                state_next = ST_KEY_CAP;
            end

            ST_KEY_CAP:
            begin
                key_next   = rd_data_reg;
                p_next     = pos_reg;
                rd_addr    = pos_reg - gap_reg;
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                we = 1'b1;
                wa = p_reg;
                if (less)
                begin
                    // shift the larger element up one gap and keep walking down
                    wd     = rd_data_reg;
                    p_next = p_dn;
                    if (p_dn >= gap_reg)
                    begin
                        rd_addr    = p_dn - gap_reg;
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        state_next = ST_PUT;
                    end
                end
                else
                begin
                    wd = key_reg;
                end
            end

            ST_PUT:
            begin
                we = 1'b1;
                wa = p_reg;
                wd = key_reg;
            end

            ST_OUT_RD:
            begin
                rd_addr    = idx_reg;
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                rd_addr = idx_reg;
                if (result.ready)
                begin
                    // fetch the next element so it is ready on the following cycle
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (is_last)
                    begin
                        n_next     = '0;
                        state_next = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // advance to the next insertion position, halving the gap at the end of a pass
        if ((state_reg == ST_PUT) || ((state_reg == ST_CMP) && !less))
        begin
            if (pos_inc == n_reg)
            begin
                gap_next = gap_half;
                pos_next = gap_half;
                state_next = (gap_half == '0) ? ST_OUT_RD : ST_KEY_RD;
            end
            else
            begin
                pos_next   = pos_inc[IW-1:0];
                state_next = ST_KEY_RD;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[wa] <= wd;
        end
        rd_data_reg <= store_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            gap_reg   <= '0;
            pos_reg   <= '0;
            p_reg     <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            gap_reg   <= gap_next;
            pos_reg   <= pos_next;
            p_reg     <= p_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule : shs_back

`default_nettype wire

// ----- src/shell_sort_halving_gaps_top.sv -----
// ---------------------------------------------------------------------------
// shell_sort_halving_gaps_top - shell sort of signed 32-bit sets
// Loads a set, sorts it ascending with halving gaps, emits it in order.
// ---------------------------------------------------------------------------
// A set is the run of elements up to the one flagged in_last, or up to the
// element that fills the MAX_ELEMENTS store. The front accepts one element
// per cycle into a 4-entry queue, so it keeps taking elements while the back
// is busy until the queue is full. The back moves one element per cycle from
// the queue into its store (one read and one write port) while the queue
// holds one, picks the first gap, then sorts in place: each insertion
// position fetches the key, fetches its neighbor one gap down and compares,
// plus one compare step per element shifted up. With n a power of two there
// are n*log2(n) - n + 1 positions. Readout fetches the first element, then
// gives one sorted element per cycle while result.ready holds, out_last on
// the final one; the back takes the next set the cycle after the final
// element is accepted. The compare-and-shift walk of the sort sets the time
// per item. No clearing pass is needed after reset.
`default_nettype none

module shell_sort_halving_gaps_top #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    shs_in_if.sink      item,
    shs_out_if.source   result
);

    logic             push_valid;
    logic             push_ready;
    shs_pkg::qitem_t  push_data;
    logic             pop_valid;
    logic             pop_ready;
    shs_pkg::qitem_t  pop_data;

    shs_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    shs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    shs_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule : shell_sort_halving_gaps_top

`default_nettype wire

// ----- src/shs_checker.sv -----
// ---------------------------------------------------------------------------
// shs_checker - port-level checks for the shell sort block
// Watches both channels and checks stall hold, ordering, set size and balance.
// ---------------------------------------------------------------------------
`default_nettype none

module shs_checker #(
    parameter int MAX_ELEMENTS = 64
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               item_valid,
    input wire logic                               item_ready,
    input wire logic                               result_valid,
    input wire logic                               result_ready,
    input wire logic signed [shs_pkg::DATA_W-1:0]  result_value,
    input wire logic                               result_last
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic                              item_take;
    logic                              res_take;
    logic signed [shs_pkg::DATA_W-1:0] prev_reg;
    logic                              have_prev_reg;
    logic [CW-1:0]                     set_cnt_reg;
    logic [15:0]                       pending_reg;

    assign item_take = item_valid && item_ready;
    assign res_take  = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            set_cnt_reg   <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            if (res_take)
            begin
                have_prev_reg <= !result_last;
                set_cnt_reg   <= result_last ? '0 : set_cnt_reg + 1'b1;
            end
            pending_reg <= pending_reg + 16'(item_take) - 16'(res_take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            prev_reg <= result_value;
        end
    end

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_value) && $stable(result_last))
        else $error("result changed while stalled");

    // emit each set in ascending order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && have_prev_reg |-> result_value >= prev_reg)
        else $error("sorted output out of order");

    // drop no set end: a set never exceeds the store
    a_set_size: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |-> set_cnt_reg < CW'(MAX_ELEMENTS))
        else $error("set longer than the store");

    // never emit more elements than were taken in
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != '0)
        else $error("result without a pending element");

endmodule : shs_checker

bind shell_sort_halving_gaps_top shs_checker #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
) u_shs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_value (result.out_value),
    .result_last  (result.out_last)
);

`default_nettype wire
